[design/svpu_pkg.sv]
// ----------------------------------------------------------------------------
// svpu_pkg
// Shared types and constants for the voice parameter unpacker.
// ----------------------------------------------------------------------------
package svpu_pkg;

    localparam int VOICE_COUNT_DEF = 32;
    localparam int MAX_RESULTS     = 3;

    localparam logic [6:0] LAST_BYTE      = 7'd127;
    localparam logic [4:0] GROUP_LAST     = 5'd16;
    localparam logic [7:0] LAST_PARAM     = 8'd154;

    typedef struct packed {
        logic [7:0] idx;
        logic [6:0] val;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t [MAX_RESULTS-1:0] res;
    } decode_t;

endpackage

[design/svpu_decode.sv]
// ----------------------------------------------------------------------------
// svpu_decode
// Splits one packed voice byte into its unpacked parameters.
// ----------------------------------------------------------------------------
module svpu_decode
(
    input  logic [7:0]        packed_byte,
    input  logic [6:0]        pos,
    input  logic [2:0]        group,
    input  logic [4:0]        group_byte,
    output svpu_pkg::decode_t dec
);

    localparam logic [6:0] NORM_LIMIT = 7'd99;
    localparam logic [6:0] NORM_MUL   = 7'd99;

    function automatic logic [6:0] norm99(input logic [6:0] v);
        logic [13:0] prod;
        logic [13:0] t;
        prod = 14'(v) * 14'(NORM_MUL);
        // floor(x / 255) for x below 2^14
        t = prod + (prod >> 8) + 14'd1;
        if (v <= NORM_LIMIT)
            return v;
        return 7'(t >> 8);
    endfunction

    logic [6:0] m;
    logic [7:0] base;
    logic [7:0] p8;
    logic [6:0] n99;

    assign m    = packed_byte[6:0];
    assign base = {1'b0, group, 4'b0} + {3'b0, group, 2'b0} + {5'b0, group};
    assign p8   = {1'b0, pos};
    assign n99  = norm99(m);

    always_comb
    begin
        dec = '0;
        if (pos < 7'd102)
        begin
            case (group_byte) inside
                [5'd0:5'd10]:
                begin
                    dec.count      = 2'd1;
                    dec.res[0].idx = base + {3'b0, group_byte};
                    dec.res[0].val = n99;
                end
                5'd11:
                begin
                    dec.count      = 2'd2;
                    dec.res[0].idx = base + 8'd11;
                    dec.res[0].val = {5'b0, packed_byte[1:0]};
                    dec.res[1].idx = base + 8'd12;
                    dec.res[1].val = {5'b0, packed_byte[3:2]};
                end
                5'd12:
                begin
                    dec.count      = 2'd2;
                    dec.res[0].idx = base + 8'd13;
                    dec.res[0].val = {4'b0, m[2:0]};
                    dec.res[1].idx = base + 8'd20;
                    dec.res[1].val = {3'b0, m[6:3]};
                end
                5'd13:
                begin
                    dec.count      = 2'd2;
                    dec.res[0].idx = base + 8'd14;
                    dec.res[0].val = {5'b0, packed_byte[1:0]};
                    dec.res[1].idx = base + 8'd15;
                    dec.res[1].val = {4'b0, packed_byte[4:2]};
                end
                5'd14:
                begin
                    dec.count      = 2'd1;
                    dec.res[0].idx = base + 8'd16;
                    dec.res[0].val = m;
                end
                5'd15:
                begin
                    dec.count      = 2'd2;
                    dec.res[0].idx = base + 8'd17;
                    dec.res[0].val = {6'b0, packed_byte[0]};
                    dec.res[1].idx = base + 8'd18;
                    dec.res[1].val = {2'b0, packed_byte[5:1]};
                end
                default:
                begin
                    dec.count      = 2'd1;
                    dec.res[0].idx = base + 8'd19;
                    dec.res[0].val = m;
                end
            endcase
        end
        else
        begin
            case (pos) inside
                [7'd102:7'd109]:
                begin
                    dec.count      = 2'd1;
                    dec.res[0].idx = p8 + 8'd24;
                    dec.res[0].val = n99;
                end
                7'd110:
                begin
                    dec.count      = 2'd1;
                    dec.res[0].idx = 8'd134;
                    dec.res[0].val = {2'b0, packed_byte[4:0]};
                end
                7'd111:
                begin
                    dec.count      = 2'd2;
                    dec.res[0].idx = 8'd135;
                    dec.res[0].val = {4'b0, packed_byte[2:0]};
                    dec.res[1].idx = 8'd136;
                    dec.res[1].val = {6'b0, packed_byte[3]};
                end
                [7'd112:7'd115]:
                begin
                    dec.count      = 2'd1;
                    dec.res[0].idx = p8 + 8'd25;
                    dec.res[0].val = m;
                end
                7'd116:
                begin
                    dec.count      = 2'd3;
                    dec.res[0].idx = 8'd141;
                    dec.res[0].val = {6'b0, m[0]};
                    dec.res[1].idx = 8'd142;
                    dec.res[1].val = {4'b0, m[3:1]};
                    dec.res[2].idx = 8'd143;
                    dec.res[2].val = {4'b0, m[6:4]};
                end
                default:
                begin
                    dec.count      = 2'd1;
                    dec.res[0].idx = p8 + 8'd27;
                    dec.res[0].val = m;
                end
            endcase
        end
    end

endmodule

[design/synth_voice_parameter_unpacker_core.sv]
// ----------------------------------------------------------------------------
// synth_voice_parameter_unpacker_core
// Unpacks a cartridge stream of packed voice bytes into indexed parameters.
//
//   channel  dir  handshake           payload
//   input    in   in_valid/in_ready   packed_byte
//   output   out  out_valid/out_ready param_index, param_value,
//                                     voice_number, last_of_voice
//
// A byte is held in the input register until each parameter it yields
// (one to three) has loaded into the single result register. The next
// byte is taken in the cycle its last result loads. Reset clears the byte
// and voice counters; no clearing pass. A stalled output holds its result
// and the input stage waits behind it.
// ----------------------------------------------------------------------------
module synth_voice_parameter_unpacker_core
#(
    parameter int VOICE_COUNT = svpu_pkg::VOICE_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] packed_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] param_index,
    output logic [6:0] param_value,
    output logic [4:0] voice_number,
    output logic       last_of_voice
);

    localparam logic [5:0] VOICE_LIMIT = 6'(VOICE_COUNT);

    // stream position counters
    logic [6:0] pos_cnt_reg;
    logic [2:0] grp_cnt_reg;
    logic [4:0] gb_cnt_reg;
    logic [4:0] voice_cnt_reg;

    // input register
    logic       a_valid_reg;
    logic [7:0] byte_reg;
    logic [6:0] pos_reg;
    logic [2:0] grp_reg;
    logic [4:0] gb_reg;
    logic [4:0] voice_reg;
    logic [1:0] sub_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] idx_reg;
    logic [6:0] val_reg;
    logic [4:0] onum_reg;
    logic       olast_reg;

    svpu_pkg::decode_t dec;
    svpu_pkg::result_t cur;
    logic              load;
    logic              last_sub;
    logic              accept;

    svpu_decode u_decode
    (
        .packed_byte (byte_reg),
        .pos         (pos_reg),
        .group       (grp_reg),
        .group_byte  (gb_reg),
        .dec         (dec)
    );

    assign cur      = dec.res[sub_reg];
    assign last_sub = (sub_reg == dec.count - 2'd1);
    assign load     = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || (load && last_sub);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_cnt_reg   <= '0;
            grp_cnt_reg   <= '0;
            gb_cnt_reg    <= '0;
            voice_cnt_reg <= '0;
            a_valid_reg   <= 1'b0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (pos_cnt_reg == svpu_pkg::LAST_BYTE)
                begin
                    pos_cnt_reg <= '0;
                    grp_cnt_reg <= '0;
                    gb_cnt_reg  <= '0;
                    if ({1'b0, voice_cnt_reg} + 6'd1 >= VOICE_LIMIT)
                        voice_cnt_reg <= '0;
                    else
                        voice_cnt_reg <= voice_cnt_reg + 5'd1;
                end
                else
                begin
                    pos_cnt_reg <= pos_cnt_reg + 7'd1;
                    if (gb_cnt_reg == svpu_pkg::GROUP_LAST)
                    begin
                        gb_cnt_reg  <= '0;
                        grp_cnt_reg <= grp_cnt_reg + 3'd1;
                    end
                    else
                        gb_cnt_reg <= gb_cnt_reg + 5'd1;
                end
                a_valid_reg <= 1'b1;
                sub_reg     <= '0;
            end
            else if (load)
            begin
                if (last_sub)
                    a_valid_reg <= 1'b0;
                else
                    sub_reg <= sub_reg + 2'd1;
            end

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= packed_byte;
            pos_reg   <= pos_cnt_reg;
            grp_reg   <= grp_cnt_reg;
            gb_reg    <= gb_cnt_reg;
            voice_reg <= voice_cnt_reg;
        end
        if (load)
        begin
            idx_reg   <= cur.idx;
            val_reg   <= cur.val;
            onum_reg  <= voice_reg;
            olast_reg <= (pos_reg == svpu_pkg::LAST_BYTE) && last_sub;
        end
    end

    assign out_valid     = out_valid_reg;
    assign param_index   = idx_reg;
    assign param_value   = val_reg;
    assign voice_number  = onum_reg;
    assign last_of_voice = olast_reg;

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (sub_reg < dec.count))
        else $error("result select beyond decoded count");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_voice |-> param_index == svpu_pkg::LAST_PARAM)
        else $error("voice end flag on wrong parameter");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> param_index <= svpu_pkg::LAST_PARAM)
        else $error("parameter index out of range");

    a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, voice_cnt_reg} < VOICE_LIMIT)
        else $error("voice counter out of range");

endmodule
